>>> src/fobh_pkg.sv
// ----------------------------------------------------------------------------
// fobh_pkg
// Shared types, constants and helpers for the first-order Heun block with
// anti-windup clamping.
// ----------------------------------------------------------------------------
package fobh_pkg;

   // Field widths
   localparam int unsigned SIG_W    = 32;  // Q16.16 signals
   localparam int unsigned COEF_W   = 32;  // Q8.24 coefficients
   localparam int unsigned DT_W     = 31;  // unsigned Q7.24 step
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned PROD_W   = 40;  // product after dropping 24 fraction bits
   localparam int unsigned SUM_W    = 42;  // headroom for saturating adds
   localparam int unsigned CSR_IDX_W = 3;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_A    = 3'd0,
      CSR_COEF_B    = 3'd1,
      CSR_COEF_D    = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_STATE_MIN = 3'd4,
      CSR_STATE_MAX = 3'd5,
      CSR_OUT_MIN   = 3'd6,
      CSR_OUT_MAX   = 3'd7
   } csr_index_type;

   // Reset values
   localparam logic signed [SIG_W-1:0] SIG_MIN = 32'sh8000_0000;
   localparam logic signed [SIG_W-1:0] SIG_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh0100_0000;
   localparam logic [DT_W-1:0] DT_RESET = 31'd167772;

   // Clamp status codes
   localparam logic [STATUS_W-1:0] STATUS_FREE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MIN  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MAX  = 2'd2;

   // Configuration bundle
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_d;
      logic [DT_W-1:0]          time_step;
      logic signed [SIG_W-1:0]  state_min;
      logic signed [SIG_W-1:0]  state_max;
      logic signed [SIG_W-1:0]  out_min;
      logic signed [SIG_W-1:0]  out_max;
   } csr_type;

   // Saturate a wide signed value to Q16.16
   function automatic logic signed [SIG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SIG_W-1:0] r;
      if (v[SUM_W-1:SIG_W-1] == {(SUM_W-SIG_W+1){v[SUM_W-1]}}) begin
         r = v[SIG_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = SIG_MIN;
      end else begin
         r = SIG_MAX;
      end
      return r;
   endfunction

endpackage

>>> src/fobh_req_if.sv
// ----------------------------------------------------------------------------
// fobh_req_if
// Input channel: one sample per transfer.
// ----------------------------------------------------------------------------
interface fobh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fobh_pkg::SIG_W-1:0]    sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

>>> src/fobh_rsp_if.sv
// ----------------------------------------------------------------------------
// fobh_rsp_if
// Result channel: new state, clamped drive and clamp status per transfer.
// ----------------------------------------------------------------------------
interface fobh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fobh_pkg::SIG_W-1:0]    state_out;
   logic signed [fobh_pkg::SIG_W-1:0]    drive_out;
   logic [fobh_pkg::STATUS_W-1:0]        clamp_status;

   modport source (output valid, output state_out, output drive_out,
                   output clamp_status, input ready);
   modport sink   (input valid, input state_out, input drive_out,
                   input clamp_status, output ready);
endinterface

>>> src/fobh_csr.sv
// ----------------------------------------------------------------------------
// fobh_csr
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module fobh_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fobh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fobh_pkg::SIG_W-1:0]         csr_wdata,
   output fobh_pkg::csr_type                  cfg
);

   fobh_pkg::csr_type cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a    <= '0;
         cfg_ff.coef_b    <= fobh_pkg::COEF_ONE;
         cfg_ff.coef_d    <= fobh_pkg::COEF_ONE;
         cfg_ff.time_step <= fobh_pkg::DT_RESET;
         cfg_ff.state_min <= fobh_pkg::SIG_MIN;
         cfg_ff.state_max <= fobh_pkg::SIG_MAX;
         cfg_ff.out_min   <= fobh_pkg::SIG_MIN;
         cfg_ff.out_max   <= fobh_pkg::SIG_MAX;
      end else if (csr_wr_en) begin
         unique case (fobh_pkg::csr_index_type'(csr_index))
            fobh_pkg::CSR_COEF_A:    cfg_ff.coef_a    <= csr_wdata;
            fobh_pkg::CSR_COEF_B:    cfg_ff.coef_b    <= csr_wdata;
            fobh_pkg::CSR_COEF_D:    cfg_ff.coef_d    <= csr_wdata;
            fobh_pkg::CSR_TIME_STEP: cfg_ff.time_step <= csr_wdata[fobh_pkg::DT_W-1:0];
            fobh_pkg::CSR_STATE_MIN: cfg_ff.state_min <= csr_wdata;
            fobh_pkg::CSR_STATE_MAX: cfg_ff.state_max <= csr_wdata;
            fobh_pkg::CSR_OUT_MIN:   cfg_ff.out_min   <= csr_wdata;
            fobh_pkg::CSR_OUT_MAX:   cfg_ff.out_max   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/fobh_mul.sv
// ----------------------------------------------------------------------------
// fobh_mul
// Shared signed 32x32 multiplier with registered, floor-shifted product.
// Drops 24 fraction bits, or 25 when the half flag folds in a factor of 0.5.
// ----------------------------------------------------------------------------
module fobh_mul (
   input  logic                                   clock,
   input  logic signed [fobh_pkg::COEF_W-1:0]     op_a,
   input  logic signed [fobh_pkg::SIG_W-1:0]      op_b,
   input  logic                                   half,
   output logic signed [fobh_pkg::PROD_W-1:0]     product
);

   localparam int unsigned FULL_W = fobh_pkg::COEF_W + fobh_pkg::SIG_W;

   logic signed [FULL_W-1:0]            full_in;
   logic signed [fobh_pkg::PROD_W-1:0]  product_in;
   logic signed [fobh_pkg::PROD_W-1:0]  product_ff;

   // Taking the upper bits of a two's complement product is a floor shift
   always_comb begin
      full_in = op_a * op_b;
      if (half) begin
         product_in = {full_in[FULL_W-1], full_in[FULL_W-1:25]};
      end else begin
         product_in = full_in[FULL_W-1:24];
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> src/first_order_block_heun_antiwindup_core.sv
// ----------------------------------------------------------------------------
// first_order_block_heun_antiwindup_core
// First-order state block: Heun integration of dx = A*x + B*u with
// anti-windup state clamp and clamped output y = x + D*u.
// ----------------------------------------------------------------------------
// One sample is taken per step. Six multiplies run in turn through a single
// shared 32x32 multiplier with a registered product, and the Heun corrector
// needs the predictor result before it can start, so a step walks ten
// sequencer states; the block takes no new sample until the step is done
// and it is back in idle. The result sits in an output register; the block
// accepts the next sample while it waits and only stalls in its last state
// if the previous result has not yet been taken.
// All arithmetic is Q16.16 signals, Q8.24 coefficients, floor rounding and
// saturation to 32 bits after every add. Limits at the full 32-bit range
// never clamp. Configuration is written through a plain write port; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module first_order_block_heun_antiwindup_core (
   input  logic                               clock,
   input  logic                               reset,
   fobh_req_if.sink                           req_ch,
   fobh_rsp_if.source                         rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [fobh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fobh_pkg::SIG_W-1:0]         csr_wdata
);

   localparam int unsigned SIG_W  = fobh_pkg::SIG_W;
   localparam int unsigned PROD_W = fobh_pkg::PROD_W;
   localparam int unsigned SUM_W  = fobh_pkg::SUM_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AX,    // issue A*x
      ST_BU,    // issue B*u
      ST_DU,    // issue D*u, form d0
      ST_DT0,   // issue dt*d0
      ST_PX,    // form predictor px
      ST_APX,   // issue A*px
      ST_S,     // form corrected slope s
      ST_DTS,   // issue dt*s/2
      ST_C,     // form c, clamp state
      ST_Y      // form output, load result
   } state_type;

   fobh_pkg::csr_type cfg;

   state_type                 state_ff;
   logic signed [SIG_W-1:0]   u_ff;
   logic signed [SIG_W-1:0]   x_ff;
   logic                      min_ff;
   logic                      max_ff;
   logic signed [PROD_W-1:0]  pa_ff;
   logic signed [PROD_W-1:0]  pb_ff;
   logic signed [SIG_W-1:0]   d0_ff;
   logic signed [SIG_W-1:0]   pd_ff;
   logic signed [SIG_W-1:0]   px_ff;
   logic signed [SIG_W-1:0]   s_ff;
   logic                      rsp_valid_ff;
   logic signed [SIG_W-1:0]   rsp_state_ff;
   logic signed [SIG_W-1:0]   rsp_drive_ff;
   logic [fobh_pkg::STATUS_W-1:0] rsp_status_ff;

   logic signed [fobh_pkg::COEF_W-1:0] mul_a;
   logic signed [SIG_W-1:0]   mul_b;
   logic                      mul_half;
   logic signed [PROD_W-1:0]  prod;

   logic signed [SIG_W-1:0]   d0_in;
   logic signed [SIG_W-1:0]   px_in;
   logic signed [SIG_W-1:0]   t_in;
   logic signed [SIG_W-1:0]   s_in;
   logic signed [SIG_W-1:0]   c_in;
   logic signed [SIG_W-1:0]   x_in;
   logic                      min_in;
   logic                      max_in;
   logic signed [SIG_W-1:0]   ysum_in;
   logic signed [SIG_W-1:0]   y_in;
   logic                      out_free;
   logic [fobh_pkg::STATUS_W-1:0] status_in;

   fobh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Multiplier operand select
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_half = 1'b0;
      unique case (state_ff)
         ST_AX:  begin mul_a = cfg.coef_a; mul_b = x_ff; end
         ST_BU:  begin mul_a = cfg.coef_b; mul_b = u_ff; end
         ST_DU:  begin mul_a = cfg.coef_d; mul_b = u_ff; end
         ST_DT0: begin mul_a = SIG_W'({1'b0, cfg.time_step}); mul_b = d0_ff; end
         ST_APX: begin mul_a = cfg.coef_a; mul_b = px_ff; end
         ST_DTS: begin
            mul_a    = SIG_W'({1'b0, cfg.time_step});
            mul_b    = s_ff;
            mul_half = 1'b1;
         end
         default: ;
      endcase
   end

   fobh_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .half    (mul_half),
      .product (prod)
   );

   // Saturating adds on the product register
   always_comb begin
      d0_in = fobh_pkg::sat32(SUM_W'(pa_ff) + SUM_W'(prod));
      px_in = fobh_pkg::sat32(SUM_W'(x_ff) + SUM_W'(prod));
      t_in  = fobh_pkg::sat32(SUM_W'(prod) + SUM_W'(pb_ff));
      s_in  = fobh_pkg::sat32(SUM_W'(t_in) + SUM_W'(d0_ff));
      c_in  = fobh_pkg::sat32(SUM_W'(x_ff) + SUM_W'(prod));
   end

   // Anti-windup clamp: a held state is released only on an inward slope
   always_comb begin
      x_in   = c_in;
      min_in = min_ff;
      max_in = max_ff;
      priority if (min_ff) begin
         if (s_ff > 0) begin
            min_in = 1'b0;
         end else begin
            x_in = cfg.state_min;
         end
      end else if (max_ff) begin
         if (s_ff < 0) begin
            max_in = 1'b0;
         end else begin
            x_in = cfg.state_max;
         end
      end else if (c_in > cfg.state_max) begin
         x_in   = cfg.state_max;
         max_in = 1'b1;
      end else if (c_in < cfg.state_min) begin
         x_in   = cfg.state_min;
         min_in = 1'b1;
      end else begin
         x_in = c_in;
      end
   end

   // Output drive and clamp status
   always_comb begin
      ysum_in = fobh_pkg::sat32(SUM_W'(x_ff) + SUM_W'(pd_ff));
      priority if (ysum_in < cfg.out_min) begin
         y_in = cfg.out_min;
      end else if (ysum_in > cfg.out_max) begin
         y_in = cfg.out_max;
      end else begin
         y_in = ysum_in;
      end
      priority if (min_ff) begin
         status_in = fobh_pkg::STATUS_MIN;
      end else if (max_ff) begin
         status_in = fobh_pkg::STATUS_MAX;
      end else begin
         status_in = fobh_pkg::STATUS_FREE;
      end
      out_free = !rsp_valid_ff || rsp_ch.ready;
   end

   // Sequencer with its datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         min_ff       <= 1'b0;
         max_ff       <= 1'b0;
      end else begin
         // result valid: set on a finished step, cleared on a transfer
         if (state_ff == ST_Y && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  u_ff     <= req_ch.sample_in;
                  state_ff <= ST_AX;
               end
            end
            ST_AX:  state_ff <= ST_BU;
            ST_BU: begin
               pa_ff    <= prod;
               state_ff <= ST_DU;
            end
            ST_DU: begin
               pb_ff    <= prod;
               d0_ff    <= d0_in;
               state_ff <= ST_DT0;
            end
            ST_DT0: begin
               pd_ff    <= fobh_pkg::sat32(SUM_W'(prod));
               state_ff <= ST_PX;
            end
            ST_PX: begin
               px_ff    <= px_in;
               state_ff <= ST_APX;
            end
            ST_APX: state_ff <= ST_S;
            ST_S: begin
               s_ff     <= s_in;
               state_ff <= ST_DTS;
            end
            ST_DTS: state_ff <= ST_C;
            ST_C: begin
               x_ff     <= x_in;
               min_ff   <= min_in;
               max_ff   <= max_in;
               state_ff <= ST_Y;
            end
            ST_Y: begin
               if (out_free) begin
                  rsp_state_ff  <= x_ff;
                  rsp_drive_ff  <= y_in;
                  rsp_status_ff <= status_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.state_out    = rsp_state_ff;
   assign rsp_ch.drive_out    = rsp_drive_ff;
   assign rsp_ch.clamp_status = rsp_status_ff;

   // Checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(min_ff && max_ff))
      else $error("state held at both limits");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_AX))
      else $error("accepted sample did not start the sequence");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Y && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished step did not load a result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == fobh_pkg::STATUS_FREE ||
                        rsp_status_ff == fobh_pkg::STATUS_MIN ||
                        rsp_status_ff == fobh_pkg::STATUS_MAX))
      else $error("undefined clamp status code");

endmodule
